FILE: design/lfbp_pkg.sv
// Package for the LED frame brightness packer.
// Holds payload structs, command and state types and shared constants.
// No dependencies.
`default_nettype none

package lfbp_pkg;

    // Store geometry: one row of three 8-bit channels per LED
    localparam int LED_COUNT    = 16;
    localparam int CH_COUNT     = 3;
    localparam int ROW_W        = $clog2(LED_COUNT);
    localparam int ROW_BITS     = CH_COUNT * 8;
    localparam int PAIR_COUNT   = (CH_COUNT * LED_COUNT) / 2;
    localparam int PAIR_W       = $clog2(PAIR_COUNT);
    localparam int HALF_PAIRS   = PAIR_COUNT / 2;
    localparam int HALF_TOP_ROW = (LED_COUNT / 2) - 1;
    localparam int TOP_CH       = CH_COUNT - 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // Input mode codes
    localparam logic [2:0] MODE_SET_CHANNEL = 3'd0;
    localparam logic [2:0] MODE_SET_COLOUR  = 3'd1;
    localparam logic [2:0] MODE_ALL_COLOUR  = 3'd2;
    localparam logic [2:0] MODE_ALL_CHANNEL = 3'd3;
    localparam logic [2:0] MODE_SEND_FRAME  = 3'd4;

    // Response curve codes
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_COARSE = 2'd1;
    localparam logic [1:0] CURVE_FINE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] CFG_CURVE       = 2'd1;
    localparam logic [1:0] CFG_COLOR_ORDER = 2'd2;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'hFF;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] led_index;
        logic [7:0] channel_index;
        logic [7:0] value;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] middle_byte;
        logic [7:0] final_byte;
        logic       latch_now;
    } t_out;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FILL,
        CMD_FRAME
    } t_cmd_kind;

    // Classified request: row write with byte enables, fill of all rows, or frame
    typedef struct packed {
        t_cmd_kind              kind;
        logic [ROW_W-1:0]       row;
        logic [CH_COUNT-1:0]    be;
        logic [ROW_BITS-1:0]    data;
    } t_cmd;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FILL,
        SEQ_FRAME
    } t_seq;

endpackage

`default_nettype wire

FILE: design/lfbp_front.sv
// Front end: accepts input requests and classifies them into store commands.
// Depends on lfbp_pkg.
`default_nettype none

module lfbp_front
    import lfbp_pkg::*;
(
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_in,
    input  wire logic i_color_order,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_ready
);

    logic                led_ok;
    logic                ch_ok;
    logic                keep;
    logic [CH_COUNT-1:0] be_ch;
    logic [ROW_BITS-1:0] data_ch;
    logic [ROW_BITS-1:0] data_col;

    // Range checks on LED and channel
    assign led_ok = (i_in.led_index < 8'(LED_COUNT));
    assign ch_ok  = (i_in.channel_index < 8'(CH_COUNT));

    // Byte enable for a single channel
    always_comb begin
        unique case (i_in.channel_index[1:0])
            2'd0:    be_ch = 3'b001;
            2'd1:    be_ch = 3'b010;
            2'd2:    be_ch = 3'b100;
            default: be_ch = 3'b000;
        endcase
    end

    // Row data: channel replicated, or colour in the selected order
    assign data_ch  = {CH_COUNT{i_in.value}};
    assign data_col = i_color_order ? {i_in.blue, i_in.red, i_in.green}
                                    : {i_in.blue, i_in.green, i_in.red};

    // Classify by mode; drop out-of-range and unused modes
    always_comb begin
        keep        = 1'b0;
        o_cmd.kind  = CMD_WRITE;
        o_cmd.row   = i_in.led_index[ROW_W-1:0];
        o_cmd.be    = be_ch;
        o_cmd.data  = data_ch;
        unique case (i_in.mode)
            MODE_SET_CHANNEL: begin
                keep = led_ok && ch_ok;
            end
            MODE_SET_COLOUR: begin
                keep       = led_ok;
                o_cmd.be   = '1;
                o_cmd.data = data_col;
            end
            MODE_ALL_COLOUR: begin
                keep       = 1'b1;
                o_cmd.kind = CMD_FILL;
                o_cmd.be   = '1;
                o_cmd.data = data_col;
            end
            MODE_ALL_CHANNEL: begin
                keep       = ch_ok;
                o_cmd.kind = CMD_FILL;
            end
            MODE_SEND_FRAME: begin
                keep       = 1'b1;
                o_cmd.kind = CMD_FRAME;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Accept whenever the queue has room; dropped requests are simply consumed
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid && keep;

endmodule

`default_nettype wire

FILE: design/lfbp_queue.sv
// Short command queue between front and back end.
// Depends on lfbp_pkg.
`default_nettype none

module lfbp_queue
    import lfbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/lfbp_back.sv
// Back end: channel store, write/fill/frame sequencer, scaling pipeline and
// output register. Depends on lfbp_pkg.
`default_nettype none

module lfbp_back
    import lfbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    input  wire logic [7:0] i_brightness,
    input  wire logic [1:0] i_curve,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_out
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [1:0]       ch;
    } t_slot;

    // Step one store entry down
    function automatic t_slot slot_dec(input t_slot s);
        t_slot d;
        d = s;
        if (s.ch == 2'd0) begin
            d.row = s.row - 1'b1;
            d.ch  = 2'(TOP_CH);
        end else begin
            d.ch = s.ch - 1'b1;
        end
        return d;
    endfunction

    // Pick a channel byte from a row, zero when the row was never written
    function automatic logic [7:0] pick(input logic [ROW_BITS-1:0] row_data,
                                       input logic vld, input logic [1:0] ch);
        logic [7:0] c;
        c = 8'd0;
        if (vld) begin
            unique case (ch)
                2'd0:    c = row_data[7:0];
                2'd1:    c = row_data[15:8];
                2'd2:    c = row_data[23:16];
                default: c = 8'd0;
            endcase
        end
        return c;
    endfunction

    // Store and row valid flags
    logic [ROW_BITS-1:0]  r_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_row_vld;

    // Sequencer
    t_seq              r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ROW_W-1:0]  r_cnt, n_cnt;
    t_slot             r_slot_a, n_slot_a;
    logic [PAIR_W-1:0] r_pair, n_pair;

    logic                en;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [CH_COUNT-1:0] wr_be;
    logic [ROW_BITS-1:0] wr_data;
    logic                issue;
    logic                issue_last;
    t_slot               slot_b;

    // Pipeline registers
    logic [ROW_BITS-1:0] r_rd_a, r_rd_b;
    logic                r_va, r_vb;
    logic [1:0]          r_ch_a, r_ch_b;
    logic                r_v1, r_l1;
    logic [15:0]         r_sq_a, r_sq_b, r_lin_a, r_lin_b;
    logic                r_v2, r_l2;
    logic [11:0]         r_val_a, r_val_b;
    logic                r_v3, r_l3;
    logic                r_o_valid;
    t_out                r_out;

    logic [7:0]  c_a, c_b;
    logic [23:0] fine_a, fine_b;
    logic [15:0] coarse_a, coarse_b;
    logic [11:0] val_a, val_b;

    // Advance the read pipeline when the output register is free or drains
    assign en     = !r_o_valid || i_ready;
    assign slot_b = slot_dec(r_slot_a);

    // Next state
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_cnt    = r_cnt;
        n_slot_a = r_slot_a;
        n_pair   = r_pair;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        CMD_WRITE: begin
                            n_state = SEQ_IDLE;
                        end
                        CMD_FILL: begin
                            n_state = SEQ_FILL;
                            n_cnt   = '0;
                        end
                        CMD_FRAME: begin
                            n_state      = SEQ_FRAME;
                            n_slot_a.row = ROW_W'(HALF_TOP_ROW);
                            n_slot_a.ch  = 2'(TOP_CH);
                            n_pair       = '0;
                        end
                        default: begin
                            n_state = SEQ_IDLE;
                        end
                    endcase
                end
            end
            SEQ_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ROW_W'(LED_COUNT - 1)) begin
                    n_state = SEQ_IDLE;
                end
            end
            SEQ_FRAME: begin
                if (en) begin
                    n_pair = r_pair + 1'b1;
                    if (r_pair == PAIR_W'(HALF_PAIRS - 1)) begin
                        n_slot_a.row = ROW_W'(LED_COUNT - 1);
                        n_slot_a.ch  = 2'(TOP_CH);
                    end else begin
                        n_slot_a = slot_dec(slot_b);
                    end
                    if (r_pair == PAIR_W'(PAIR_COUNT - 1)) begin
                        n_state = SEQ_IDLE;
                    end
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: store writes, command pop, frame read issue
    always_comb begin
        o_cmd_pop  = 1'b0;
        wr_en      = 1'b0;
        wr_row     = i_cmd.row;
        wr_be      = i_cmd.be;
        wr_data    = i_cmd.data;
        issue      = 1'b0;
        issue_last = (r_pair == PAIR_W'(PAIR_COUNT - 1));
        unique case (r_state)
            SEQ_IDLE: begin
                o_cmd_pop = 1'b1;
                wr_en     = i_cmd_valid && (i_cmd.kind == CMD_WRITE);
            end
            SEQ_FILL: begin
                wr_en   = 1'b1;
                wr_row  = r_cnt;
                wr_be   = r_cmd.be;
                wr_data = r_cmd.data;
            end
            SEQ_FRAME: begin
                issue = en;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cnt    <= n_cnt;
        r_slot_a <= n_slot_a;
        r_pair   <= n_pair;
    end

    // Store write: unwritten bytes of a fresh row become zero
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < CH_COUNT; b++) begin
                if (wr_be[b]) begin
                    r_mem[wr_row][b*8 +: 8] <= wr_data[b*8 +: 8];
                end else if (!r_row_vld[wr_row]) begin
                    r_mem[wr_row][b*8 +: 8] <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_row] <= 1'b1;
        end
    end

    // Store read: two rows per pair, registered
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_a <= r_mem[r_slot_a.row];
            r_rd_b <= r_mem[slot_b.row];
            r_va   <= r_row_vld[r_slot_a.row];
            r_vb   <= r_row_vld[slot_b.row];
            r_ch_a <= r_slot_a.ch;
            r_ch_b <= slot_b.ch;
            r_l1   <= issue_last;
        end
    end

    // Square and linear products
    assign c_a = pick(r_rd_a, r_va, r_ch_a);
    assign c_b = pick(r_rd_b, r_vb, r_ch_b);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_a  <= 16'(c_a) * 16'(c_a);
            r_sq_b  <= 16'(c_b) * 16'(c_b);
            r_lin_a <= 16'(c_a) * 16'(i_brightness);
            r_lin_b <= 16'(c_b) * 16'(i_brightness);
            r_l2    <= r_l1;
        end
    end

    // Apply brightness to the square and select the curve
    assign fine_a   = 24'(r_sq_a) * 24'(i_brightness);
    assign fine_b   = 24'(r_sq_b) * 24'(i_brightness);
    assign coarse_a = 16'(r_sq_a[15:4]) * 16'(i_brightness[7:4]);
    assign coarse_b = 16'(r_sq_b[15:4]) * 16'(i_brightness[7:4]);

    always_comb begin
        unique case (i_curve)
            CURVE_COARSE: begin
                val_a = coarse_a[15:4];
                val_b = coarse_b[15:4];
            end
            CURVE_FINE: begin
                val_a = fine_a[23:12];
                val_b = fine_b[23:12];
            end
            default: begin
                val_a = r_lin_a[15:4];
                val_b = r_lin_b[15:4];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val_a <= val_a;
            r_val_b <= val_b;
            r_l3    <= r_l2;
        end
    end

    // Pack two 12-bit values into a byte triple
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.first_byte  <= r_val_a[11:4];
            r_out.middle_byte <= {r_val_a[3:0], r_val_b[11:8]};
            r_out.final_byte  <= r_val_b[7:0];
            r_out.latch_now   <= r_l3;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v1      <= issue;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_o_valid <= r_v3;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

FILE: design/led_frame_brightness_packer.sv
// A frame send at the queue head enters the frame state; its store reads pass the read,
// product, curve and output registers, giving 24 triples, one per cycle unless stalled.
// A one-LED write is done in the idle state; an all-LED write fills the 16 rows in turn.
// Output stalls freeze the frame pipeline; one store pair is read per cycle.
// Synchronous active-low reset sets the state, valid and config registers, the queue
// and the row valid flags; the store reads as zero at once, with no clearing pass.
`default_nettype none

module led_frame_brightness_packer
    import lfbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_out,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_brightness;
    logic [1:0] r_curve;
    logic       r_color_order;

    logic front_valid;
    t_cmd front_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness  <= BRIGHTNESS_RESET;
            r_curve       <= CURVE_LINEAR;
            r_color_order <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BRIGHTNESS:  r_brightness  <= i_cfg_data;
                CFG_CURVE:       r_curve       <= i_cfg_data[1:0];
                CFG_COLOR_ORDER: r_color_order <= i_cfg_data[0];
                default: begin
                    r_brightness <= r_brightness;
                end
            endcase
        end
    end

    lfbp_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in          (i_in),
        .i_color_order (r_color_order),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_cmd_ready   (q_ready)
    );

    lfbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    lfbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .i_brightness (r_brightness),
        .i_curve      (r_curve),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
